/* src/itrb_pkg.sv */
// ----------------------------------------------------------------------------
// itrb_pkg
// Types and constants shared by the I2C target register bank.
// ----------------------------------------------------------------------------
package itrb_pkg;

   localparam int unsigned REGISTER_COUNT = 101;
   localparam int unsigned WINDOW_SIZE    = 32;
   localparam int unsigned LED_MAX        = 8;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef enum logic [2:0] {
      OP_START_WRITE = 3'd0,
      OP_WRITE_BYTE  = 3'd1,
      OP_READ_BYTE   = 3'd2,
      OP_STOP        = 3'd3,
      OP_BUS_RESET   = 3'd4,
      OP_RAISE_IRQ   = 3'd5,
      OP_SET_GP      = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_EEPROM_WRITE = 3'd1,
      ACT_EEPROM_READ  = 3'd2,
      ACT_LED_DRIVE    = 3'd3,
      ACT_TPU_POWER    = 3'd4,
      ACT_LOCK_CODE    = 3'd5,
      ACT_COMMAND      = 3'd6
   } act_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOARD_TYPE       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRMWARE_VERSION = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HARDWARE_VERSION = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DDR_TYPE         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORK_MODE        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LED_COUNT        = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEST_IRQ_MASK    = 3'd6;

   // register bank map
   localparam logic [6:0] REG_BOARD_KIND   = 7'h00;
   localparam logic [6:0] REG_FW_VERSION   = 7'h01;
   localparam logic [6:0] REG_HW_VERSION   = 7'h02;
   localparam logic [6:0] REG_COMMAND      = 7'h03;
   localparam logic [6:0] REG_IRQ_STATUS   = 7'h06;
   localparam logic [6:0] REG_TEST_IRQ     = 7'h07;
   localparam logic [6:0] REG_RESERVED_08  = 7'h08;
   localparam logic [6:0] REG_RESET_COUNT  = 7'h0a;
   localparam logic [6:0] REG_RUNTIME_LO   = 7'h0b;
   localparam logic [6:0] REG_RUNTIME_HI   = 7'h0c;
   localparam logic [6:0] REG_GP           = 7'h14;
   localparam logic [6:0] REG_DDR_TYPE     = 7'h15;
   localparam logic [6:0] REG_ONE          = 7'h16;
   localparam logic [6:0] REG_WORK_MODE    = 7'h17;
   localparam logic [6:0] REG_TPU_POWER    = 7'h22;
   localparam logic [6:0] REG_WATTS_LO     = 7'h24;
   localparam logic [6:0] REG_WATTS_HI     = 7'h25;
   localparam logic [6:0] REG_AMPS_LO      = 7'h28;
   localparam logic [6:0] REG_AMPS_HI      = 7'h29;
   localparam logic [6:0] REG_LED          = 7'h30;
   localparam logic [6:0] REG_BOOT_STEP    = 7'h3c;
   localparam logic [6:0] REG_BOARD_ID     = 7'h3d;
   localparam logic [6:0] REG_EE_BASE_LO   = 7'h3e;
   localparam logic [6:0] REG_EE_BASE_HI   = 7'h3f;
   localparam logic [6:0] REG_WINDOW       = 7'h40;
   localparam logic [6:0] REG_LOCK         = 7'h60;
   localparam logic [6:0] REG_BOARD_ADDR0  = 7'h61;
   localparam logic [6:0] REG_BOARD_ADDR1  = 7'h62;
   localparam logic [6:0] REG_BOARD_ADDR2  = 7'h63;
   localparam logic [6:0] REG_BOARD_ADDR3  = 7'h64;

   localparam logic [7:0] TEST_IRQ_CODE  = 8'h5a;
   localparam logic [7:0] UNMAPPED_BYTE  = 8'hff;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  data;
      logic [15:0] uptime;
      logic [15:0] current;
      logic [7:0]  reset_count;
      logic [7:0]  led_levels;
      logic [7:0]  stage;
      logic [7:0]  eeprom_byte;
      logic [7:0]  eeprom_locked;
      logic [7:0]  tpu_power_state;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        irq;
      logic [2:0]  action;
      logic [15:0] action_address;
      logic [7:0]  action_value;
   } rsp_type;

   typedef struct packed {
      logic [7:0] board_type;
      logic [7:0] firmware_version;
      logic [7:0] hardware_version;
      logic [7:0] ddr_type;
      logic [7:0] work_mode;
      logic [3:0] led_count;
      logic [7:0] test_interrupt_mask;
   } cfg_type;

endpackage

/* src/itrb_channels.sv */
// ----------------------------------------------------------------------------
// itrb channels
// Valid/ready channel interfaces for requests, responses and CSR writes.
// ----------------------------------------------------------------------------
interface itrb_req_if;
   logic              valid;
   logic              ready;
   itrb_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface itrb_rsp_if;
   logic              valid;
   logic              ready;
   itrb_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface itrb_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [itrb_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [7:0]                           data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/i2c_target_register_bank.sv */
// ----------------------------------------------------------------------------
// i2c_target_register_bank
// Register bank of an I2C target: index, decode, EEPROM window, actions.
// ----------------------------------------------------------------------------
//  channel   interface       dir   accepted when
//  req_if    itrb_req_if     in    req_if.valid & req_if.ready
//  rsp_if    itrb_rsp_if     out   rsp_if.valid & rsp_if.ready
//  csr_if    itrb_csr_if     in    csr_if.valid (ready always high)
//
//  One item per cycle while the response is not stalled; an accepted item
//  passes the input register, decode and the output register to the response.
//  Synchronous active-high reset clears the bank state and restores the
//  configuration defaults.
//  A stalled response holds the output register; the input register keeps
//  accepting until it too is full.
// ----------------------------------------------------------------------------
module i2c_target_register_bank (
   input  logic       clock,
   input  logic       reset,
   itrb_req_if.sink   req_if,
   itrb_rsp_if.source rsp_if,
   itrb_csr_if.sink   csr_if
);

   itrb_pkg::req_type req_ff;
   logic              req_valid_ff, req_valid_in;
   itrb_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   itrb_pkg::rsp_type rsp_next;
   itrb_pkg::cfg_type cfg;
   logic              advance;
   logic              req_take;

   itrb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   itrb_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready   = !req_valid_ff || advance;
   assign req_take       = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_if.payload;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

endmodule

/* src/itrb_csr.sv */
// ----------------------------------------------------------------------------
// itrb_csr
// Configuration registers, written through the CSR channel.
// ----------------------------------------------------------------------------
module itrb_csr (
   input  logic              clock,
   input  logic              reset,
   itrb_csr_if.sink          csr_if,
   output itrb_pkg::cfg_type cfg
);

   // all fields zero except the test interrupt mask, which resets to 1
   localparam itrb_pkg::cfg_type CfgReset = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 8'h01};

   itrb_pkg::cfg_type cfg_ff;
   itrb_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            itrb_pkg::CSR_BOARD_TYPE:       cfg_in.board_type          = csr_if.data;
            itrb_pkg::CSR_FIRMWARE_VERSION: cfg_in.firmware_version    = csr_if.data;
            itrb_pkg::CSR_HARDWARE_VERSION: cfg_in.hardware_version    = csr_if.data;
            itrb_pkg::CSR_DDR_TYPE:         cfg_in.ddr_type            = csr_if.data;
            itrb_pkg::CSR_WORK_MODE:        cfg_in.work_mode           = csr_if.data;
            itrb_pkg::CSR_LED_COUNT:        cfg_in.led_count           = csr_if.data[3:0];
            itrb_pkg::CSR_TEST_IRQ_MASK:    cfg_in.test_interrupt_mask = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/itrb_core.sv */
// ----------------------------------------------------------------------------
// itrb_core
// Register bank state and byte decode; state commits when an item advances.
// ----------------------------------------------------------------------------
module itrb_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  itrb_pkg::req_type req,
   input  itrb_pkg::cfg_type cfg,
   output itrb_pkg::rsp_type rsp
);

   logic [6:0]  index_ff,           index_in;
   logic        index_pending_ff,   index_pending_in;
   logic [7:0]  pending_command_ff, pending_command_in;
   logic [7:0]  irq_status_ff,      irq_status_in;
   logic [7:0]  gp_ff,              gp_in;
   logic [15:0] eeprom_base_ff,     eeprom_base_in;
   logic [15:0] latched_word_ff,    latched_word_in;
   logic [7:0]  board_id_ff,        board_id_in;
   logic [7:0]  board_address_ff [4];
   logic [7:0]  board_address_in [4];

   logic [3:0]  led_num;
   logic [7:0]  led_mask;
   logic        in_window;
   logic [15:0] window_address;
   logic [7:0]  index_next;
   logic [6:0]  index_wrapped;
   logic [7:0]  data_mod;
   logic [1:0]  addr_slot;
   logic [15:0] power_word;

   itrb_pkg::op_type  op;
   itrb_pkg::act_type act;
   logic [7:0]        read_data;
   logic [15:0]       act_address;
   logic [7:0]        act_value;

   localparam logic [7:0] RegCount  = 8'(itrb_pkg::REGISTER_COUNT);
   localparam logic [7:0] RegCount2 = 8'(2 * itrb_pkg::REGISTER_COUNT);
   localparam logic [7:0] WindowEnd = 8'(7'h40 + itrb_pkg::WINDOW_SIZE);
   localparam logic [3:0] LedMax    = 4'(itrb_pkg::LED_MAX);

   assign op       = itrb_pkg::op_type'(req.operation);
   assign led_num  = (cfg.led_count > LedMax) ? LedMax : cfg.led_count;
   assign led_mask = 8'((9'd1 << led_num) - 9'd1);

   assign in_window      = (index_ff >= itrb_pkg::REG_WINDOW) &&
                           ({1'b0, index_ff} < WindowEnd);
   assign window_address = eeprom_base_ff + {9'd0, 7'(index_ff - itrb_pkg::REG_WINDOW)};
   assign addr_slot      = 2'(index_ff - itrb_pkg::REG_BOARD_ADDR0);
   assign power_word     = 16'({req.current, 3'd0}) + 16'({req.current, 2'd0});

   assign index_next    = {1'b0, index_ff} + 8'd1;
   assign index_wrapped = (index_next == RegCount) ? 7'd0 : index_next[6:0];

   always_comb begin
      if (req.data >= RegCount2) begin
         data_mod = req.data - RegCount2;
      end else if (req.data >= RegCount) begin
         data_mod = req.data - RegCount;
      end else begin
         data_mod = req.data;
      end
   end

   always_comb begin
      index_in           = index_ff;
      index_pending_in   = index_pending_ff;
      pending_command_in = pending_command_ff;
      irq_status_in      = irq_status_ff;
      gp_in              = gp_ff;
      eeprom_base_in     = eeprom_base_ff;
      latched_word_in    = latched_word_ff;
      board_id_in        = board_id_ff;
      board_address_in   = board_address_ff;
      act                = itrb_pkg::ACT_NONE;
      read_data          = 8'd0;
      act_address        = 16'd0;
      act_value          = 8'd0;

      unique case (op)
         itrb_pkg::OP_START_WRITE: begin
            index_pending_in = 1'b1;
         end
         itrb_pkg::OP_WRITE_BYTE: begin
            if (index_pending_ff) begin
               index_in         = data_mod[6:0];
               index_pending_in = 1'b0;
            end else begin
               index_in = index_wrapped;
               if (in_window) begin
                  act         = itrb_pkg::ACT_EEPROM_WRITE;
                  act_address = window_address;
                  act_value   = req.data;
               end else begin
                  unique case (index_ff)
                     itrb_pkg::REG_COMMAND:    pending_command_in = req.data;
                     itrb_pkg::REG_IRQ_STATUS: irq_status_in = irq_status_ff & ~req.data;
                     itrb_pkg::REG_TEST_IRQ: begin
                        if (req.data == itrb_pkg::TEST_IRQ_CODE) begin
                           irq_status_in = irq_status_ff | cfg.test_interrupt_mask;
                        end
                     end
                     itrb_pkg::REG_GP:         gp_in = req.data;
                     itrb_pkg::REG_TPU_POWER: begin
                        act       = itrb_pkg::ACT_TPU_POWER;
                        act_value = req.data;
                     end
                     itrb_pkg::REG_LED: begin
                        act       = itrb_pkg::ACT_LED_DRIVE;
                        act_value = req.data & led_mask;
                     end
                     itrb_pkg::REG_BOARD_ID:   board_id_in = req.data;
                     itrb_pkg::REG_EE_BASE_LO: eeprom_base_in[7:0]  = req.data;
                     itrb_pkg::REG_EE_BASE_HI: eeprom_base_in[15:8] = req.data;
                     itrb_pkg::REG_LOCK: begin
                        act       = itrb_pkg::ACT_LOCK_CODE;
                        act_value = req.data;
                     end
                     itrb_pkg::REG_BOARD_ADDR0, itrb_pkg::REG_BOARD_ADDR1,
                     itrb_pkg::REG_BOARD_ADDR2, itrb_pkg::REG_BOARD_ADDR3: begin
                        board_address_in[addr_slot] = req.data;
                     end
                     default: ;
                  endcase
               end
            end
         end
         itrb_pkg::OP_READ_BYTE: begin
            index_in = index_wrapped;
            if (in_window) begin
               act         = itrb_pkg::ACT_EEPROM_READ;
               act_address = window_address;
               read_data   = req.eeprom_byte;
            end else begin
               unique case (index_ff)
                  itrb_pkg::REG_BOARD_KIND:  read_data = cfg.board_type;
                  itrb_pkg::REG_FW_VERSION:  read_data = cfg.firmware_version;
                  itrb_pkg::REG_HW_VERSION:  read_data = cfg.hardware_version;
                  itrb_pkg::REG_COMMAND:     read_data = 8'd0;
                  itrb_pkg::REG_IRQ_STATUS:  read_data = irq_status_ff;
                  itrb_pkg::REG_RESERVED_08: read_data = 8'd0;
                  itrb_pkg::REG_RESET_COUNT: read_data = req.reset_count;
                  itrb_pkg::REG_RUNTIME_LO: begin
                     latched_word_in = req.uptime;
                     read_data       = req.uptime[7:0];
                  end
                  itrb_pkg::REG_RUNTIME_HI:  read_data = latched_word_ff[15:8];
                  itrb_pkg::REG_GP:          read_data = gp_ff;
                  itrb_pkg::REG_DDR_TYPE:    read_data = cfg.ddr_type;
                  itrb_pkg::REG_ONE:         read_data = 8'd1;
                  itrb_pkg::REG_WORK_MODE:   read_data = cfg.work_mode;
                  itrb_pkg::REG_TPU_POWER:   read_data = req.tpu_power_state;
                  itrb_pkg::REG_WATTS_LO: begin
                     latched_word_in = power_word;
                     read_data       = power_word[7:0];
                  end
                  itrb_pkg::REG_WATTS_HI:    read_data = latched_word_ff[15:8];
                  itrb_pkg::REG_AMPS_LO: begin
                     latched_word_in = req.current;
                     read_data       = req.current[7:0];
                  end
                  itrb_pkg::REG_AMPS_HI:     read_data = latched_word_ff[15:8];
                  itrb_pkg::REG_LED:         read_data = req.led_levels | ~led_mask;
                  itrb_pkg::REG_BOOT_STEP:   read_data = req.stage;
                  itrb_pkg::REG_BOARD_ID:    read_data = board_id_ff;
                  itrb_pkg::REG_EE_BASE_LO:  read_data = eeprom_base_ff[7:0];
                  itrb_pkg::REG_EE_BASE_HI:  read_data = eeprom_base_ff[15:8];
                  itrb_pkg::REG_LOCK:        read_data = req.eeprom_locked;
                  itrb_pkg::REG_BOARD_ADDR0, itrb_pkg::REG_BOARD_ADDR1,
                  itrb_pkg::REG_BOARD_ADDR2, itrb_pkg::REG_BOARD_ADDR3: begin
                     read_data = board_address_ff[addr_slot];
                  end
                  default:                   read_data = itrb_pkg::UNMAPPED_BYTE;
               endcase
            end
         end
         itrb_pkg::OP_STOP: begin
            if (pending_command_ff != 8'd0) begin
               act                = itrb_pkg::ACT_COMMAND;
               act_value          = pending_command_ff;
               pending_command_in = 8'd0;
            end
         end
         itrb_pkg::OP_BUS_RESET: begin
            index_in           = 7'd0;
            index_pending_in   = 1'b0;
            pending_command_in = 8'd0;
            irq_status_in      = 8'd0;
            gp_in              = 8'd0;
            eeprom_base_in     = 16'd0;
            latched_word_in    = 16'd0;
            board_id_in        = 8'd0;
            board_address_in   = '{default: 8'd0};
         end
         itrb_pkg::OP_RAISE_IRQ: begin
            irq_status_in = irq_status_ff | req.data;
         end
         itrb_pkg::OP_SET_GP: begin
            gp_in = req.data;
         end
         default: ;
      endcase
   end

   assign rsp = {read_data, (irq_status_in != 8'd0), act, act_address, act_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff           <= 7'd0;
         index_pending_ff   <= 1'b0;
         pending_command_ff <= 8'd0;
         irq_status_ff      <= 8'd0;
         gp_ff              <= 8'd0;
         eeprom_base_ff     <= 16'd0;
         latched_word_ff    <= 16'd0;
         board_id_ff        <= 8'd0;
         board_address_ff   <= '{default: 8'd0};
      end else if (advance) begin
         index_ff           <= index_in;
         index_pending_ff   <= index_pending_in;
         pending_command_ff <= pending_command_in;
         irq_status_ff      <= irq_status_in;
         gp_ff              <= gp_in;
         eeprom_base_ff     <= eeprom_base_in;
         latched_word_ff    <= latched_word_in;
         board_id_ff        <= board_id_in;
         board_address_ff   <= board_address_in;
      end
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus byte events into the I2C target register bank and checks each
// response against a cycle-free model of the bank held here. A short table of
// directed items comes first, then random transfers under several register
// settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [2:0]  OP_UNDEFINED = 3'd7;
   localparam logic [2:0]  CSR_UNUSED   = 3'd7;
   localparam int unsigned POWER_SCALE  = 12;
   localparam int unsigned RUN_LIMIT_NS = 2_000_000;

   localparam logic [6:0] MAPPED [27] = '{
      itrb_pkg::REG_BOARD_KIND, itrb_pkg::REG_FW_VERSION, itrb_pkg::REG_HW_VERSION,
      itrb_pkg::REG_COMMAND, itrb_pkg::REG_IRQ_STATUS, itrb_pkg::REG_TEST_IRQ,
      itrb_pkg::REG_RESERVED_08, itrb_pkg::REG_RESET_COUNT, itrb_pkg::REG_RUNTIME_LO,
      itrb_pkg::REG_RUNTIME_HI, itrb_pkg::REG_GP, itrb_pkg::REG_DDR_TYPE,
      itrb_pkg::REG_ONE, itrb_pkg::REG_WORK_MODE, itrb_pkg::REG_TPU_POWER,
      itrb_pkg::REG_WATTS_LO, itrb_pkg::REG_WATTS_HI, itrb_pkg::REG_AMPS_LO,
      itrb_pkg::REG_AMPS_HI, itrb_pkg::REG_LED, itrb_pkg::REG_BOOT_STEP,
      itrb_pkg::REG_BOARD_ID, itrb_pkg::REG_EE_BASE_LO, itrb_pkg::REG_EE_BASE_HI,
      itrb_pkg::REG_LOCK, itrb_pkg::REG_BOARD_ADDR0, itrb_pkg::REG_BOARD_ADDR3
   };

   typedef struct {
      logic [2:0]        op;
      logic [7:0]        data;
      bit                typed;
      itrb_pkg::rsp_type reply;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itrb_req_if req_if ();
   itrb_rsp_if rsp_if ();
   itrb_csr_if csr_if ();

   i2c_target_register_bank DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of the bank
   itrb_pkg::cfg_type bank_cfg;
   logic [6:0] reg_index;
   bit         index_armed;
   logic [7:0] command_byte;
   logic [7:0] irq_status;
   logic [7:0] gp_byte;
   logic [15:0] ee_base;
   logic [15:0] word_latch;
   logic [7:0] board_id_byte;
   logic [7:0] board_addr [4];

   itrb_pkg::rsp_type pending_replies [$];
   int unsigned mismatches = 0;
   bit      no_gaps = 1'b0;
   bit      row_typed;
   itrb_pkg::rsp_type row_reply;
   stim_row_type directed [28];

   function automatic void clear_bank();
      reg_index     = '0;
      index_armed   = 1'b0;
      command_byte  = '0;
      irq_status    = '0;
      gp_byte       = '0;
      ee_base       = '0;
      word_latch    = '0;
      board_id_byte = '0;
      foreach (board_addr[k]) board_addr[k] = '0;
   endfunction

   function automatic void apply_setting(logic [2:0] idx, logic [7:0] value);
      case (idx)
         itrb_pkg::CSR_BOARD_TYPE:       bank_cfg.board_type = value;
         itrb_pkg::CSR_FIRMWARE_VERSION: bank_cfg.firmware_version = value;
         itrb_pkg::CSR_HARDWARE_VERSION: bank_cfg.hardware_version = value;
         itrb_pkg::CSR_DDR_TYPE:         bank_cfg.ddr_type = value;
         itrb_pkg::CSR_WORK_MODE:        bank_cfg.work_mode = value;
         itrb_pkg::CSR_LED_COUNT:        bank_cfg.led_count = value[3:0];
         itrb_pkg::CSR_TEST_IRQ_MASK:    bank_cfg.test_interrupt_mask = value;
         default: ;
      endcase
   endfunction

   function automatic bit in_window(logic [6:0] at);
      return (int'(at) >= int'(itrb_pkg::REG_WINDOW)) &&
             (int'(at) < int'(itrb_pkg::REG_WINDOW) + itrb_pkg::WINDOW_SIZE);
   endfunction

   function automatic logic [15:0] window_address(logic [6:0] at);
      return 16'(ee_base + 16'(at - itrb_pkg::REG_WINDOW));
   endfunction

   function automatic logic [6:0] next_index(logic [6:0] at);
      return (at == 7'(itrb_pkg::REGISTER_COUNT - 1)) ? 7'd0 : at + 7'd1;
   endfunction

   function automatic itrb_pkg::rsp_type bank_access(itrb_pkg::req_type it);
      itrb_pkg::rsp_type r;
      logic [6:0] at;
      logic [3:0] wired;
      logic [7:0] led_bits;
      r = '0;
      at = reg_index;
      wired = (int'(bank_cfg.led_count) > itrb_pkg::LED_MAX) ?
              4'(itrb_pkg::LED_MAX) : bank_cfg.led_count;
      led_bits = 8'((16'd1 << wired) - 16'd1);
      case (it.operation)
         itrb_pkg::OP_START_WRITE: index_armed = 1'b1;
         itrb_pkg::OP_WRITE_BYTE: begin
            if (index_armed) begin
               reg_index = 7'(it.data % itrb_pkg::REGISTER_COUNT);
               index_armed = 1'b0;
            end else begin
               if (in_window(at)) begin
                  r.action = itrb_pkg::ACT_EEPROM_WRITE;
                  r.action_address = window_address(at);
                  r.action_value = it.data;
               end else begin
                  case (at)
                     itrb_pkg::REG_COMMAND:    command_byte = it.data;
                     itrb_pkg::REG_IRQ_STATUS: irq_status &= ~it.data;
                     itrb_pkg::REG_TEST_IRQ: begin
                        if (it.data == itrb_pkg::TEST_IRQ_CODE)
                           irq_status |= bank_cfg.test_interrupt_mask;
                     end
                     itrb_pkg::REG_GP:         gp_byte = it.data;
                     itrb_pkg::REG_TPU_POWER: begin
                        r.action = itrb_pkg::ACT_TPU_POWER;
                        r.action_value = it.data;
                     end
                     itrb_pkg::REG_LED: begin
                        r.action = itrb_pkg::ACT_LED_DRIVE;
                        r.action_value = it.data & led_bits;
                     end
                     itrb_pkg::REG_BOARD_ID:   board_id_byte = it.data;
                     itrb_pkg::REG_EE_BASE_LO: ee_base[7:0] = it.data;
                     itrb_pkg::REG_EE_BASE_HI: ee_base[15:8] = it.data;
                     itrb_pkg::REG_LOCK: begin
                        r.action = itrb_pkg::ACT_LOCK_CODE;
                        r.action_value = it.data;
                     end
                     itrb_pkg::REG_BOARD_ADDR0, itrb_pkg::REG_BOARD_ADDR1,
                     itrb_pkg::REG_BOARD_ADDR2, itrb_pkg::REG_BOARD_ADDR3:
                        board_addr[2'(at - itrb_pkg::REG_BOARD_ADDR0)] = it.data;
                     default: ;
                  endcase
               end
               reg_index = next_index(at);
            end
         end
         itrb_pkg::OP_READ_BYTE: begin
            if (in_window(at)) begin
               r.action = itrb_pkg::ACT_EEPROM_READ;
               r.action_address = window_address(at);
               r.read_data = it.eeprom_byte;
            end else begin
               case (at)
                  itrb_pkg::REG_BOARD_KIND:  r.read_data = bank_cfg.board_type;
                  itrb_pkg::REG_FW_VERSION:  r.read_data = bank_cfg.firmware_version;
                  itrb_pkg::REG_HW_VERSION:  r.read_data = bank_cfg.hardware_version;
                  itrb_pkg::REG_COMMAND, itrb_pkg::REG_RESERVED_08: r.read_data = '0;
                  itrb_pkg::REG_IRQ_STATUS:  r.read_data = irq_status;
                  itrb_pkg::REG_RESET_COUNT: r.read_data = it.reset_count;
                  itrb_pkg::REG_RUNTIME_LO: begin
                     word_latch = it.uptime;
                     r.read_data = word_latch[7:0];
                  end
                  itrb_pkg::REG_RUNTIME_HI, itrb_pkg::REG_WATTS_HI, itrb_pkg::REG_AMPS_HI:
                     r.read_data = word_latch[15:8];
                  itrb_pkg::REG_GP:          r.read_data = gp_byte;
                  itrb_pkg::REG_DDR_TYPE:    r.read_data = bank_cfg.ddr_type;
                  itrb_pkg::REG_ONE:         r.read_data = 8'd1;
                  itrb_pkg::REG_WORK_MODE:   r.read_data = bank_cfg.work_mode;
                  itrb_pkg::REG_TPU_POWER:   r.read_data = it.tpu_power_state;
                  itrb_pkg::REG_WATTS_LO: begin
                     word_latch = 16'(it.current * POWER_SCALE);
                     r.read_data = word_latch[7:0];
                  end
                  itrb_pkg::REG_AMPS_LO: begin
                     word_latch = it.current;
                     r.read_data = word_latch[7:0];
                  end
                  itrb_pkg::REG_LED:         r.read_data = ~(~it.led_levels & led_bits);
                  itrb_pkg::REG_BOOT_STEP:   r.read_data = it.stage;
                  itrb_pkg::REG_BOARD_ID:    r.read_data = board_id_byte;
                  itrb_pkg::REG_EE_BASE_LO:  r.read_data = ee_base[7:0];
                  itrb_pkg::REG_EE_BASE_HI:  r.read_data = ee_base[15:8];
                  itrb_pkg::REG_LOCK:        r.read_data = it.eeprom_locked;
                  itrb_pkg::REG_BOARD_ADDR0, itrb_pkg::REG_BOARD_ADDR1,
                  itrb_pkg::REG_BOARD_ADDR2, itrb_pkg::REG_BOARD_ADDR3:
                     r.read_data = board_addr[2'(at - itrb_pkg::REG_BOARD_ADDR0)];
                  default:                   r.read_data = itrb_pkg::UNMAPPED_BYTE;
               endcase
            end
            reg_index = next_index(at);
         end
         itrb_pkg::OP_STOP: begin
            if (command_byte != '0) begin
               r.action = itrb_pkg::ACT_COMMAND;
               r.action_value = command_byte;
               command_byte = '0;
            end
         end
         itrb_pkg::OP_BUS_RESET: clear_bank();
         itrb_pkg::OP_RAISE_IRQ: irq_status |= it.data;
         itrb_pkg::OP_SET_GP:    gp_byte = it.data;
         default: ;
      endcase
      r.irq = (irq_status != '0);
      return r;
   endfunction

   function automatic void compare_field(string field, int unsigned got, int unsigned want);
      if (got != want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : bank_monitor
      itrb_pkg::rsp_type want;
      if (reset) begin
         clear_bank();
         bank_cfg = '0;
         bank_cfg.test_interrupt_mask = 8'd1;
         pending_replies.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) apply_setting(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) begin
            want = bank_access(req_if.payload);
            if (row_typed) want = row_reply;
            pending_replies.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t: response with nothing outstanding", $time);
            end else begin
               want = pending_replies.pop_front();
               compare_field("read_data", rsp_if.payload.read_data, want.read_data);
               compare_field("irq", rsp_if.payload.irq, want.irq);
               compare_field("action", rsp_if.payload.action, want.action);
               compare_field("action_address", rsp_if.payload.action_address,
                             want.action_address);
               compare_field("action_value", rsp_if.payload.action_value, want.action_value);
            end
         end
      end
   end

   function automatic itrb_pkg::rsp_type reply(logic [7:0] rd, logic irq,
                                               itrb_pkg::act_type act = itrb_pkg::ACT_NONE,
                                               logic [15:0] addr = '0,
                                               logic [7:0] val = '0);
      itrb_pkg::rsp_type r;
      r.read_data = rd;
      r.irq = irq;
      r.action = act;
      r.action_address = addr;
      r.action_value = val;
      return r;
   endfunction

   function automatic stim_row_type known(logic [2:0] op, logic [7:0] data,
                                          itrb_pkg::rsp_type r);
      stim_row_type s;
      s.op = op;
      s.data = data;
      s.typed = 1'b1;
      s.reply = r;
      return s;
   endfunction

   function automatic stim_row_type free_row(logic [2:0] op, logic [7:0] data);
      stim_row_type s;
      s.op = op;
      s.data = data;
      s.typed = 1'b0;
      s.reply = '0;
      return s;
   endfunction

   function automatic logic [15:0] edge_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic itrb_pkg::req_type bus_item(logic [2:0] op, logic [7:0] data);
      itrb_pkg::req_type it;
      it.operation = op;
      it.data = data;
      it.uptime = edge_word();
      it.current = edge_word();
      it.reset_count = 8'($urandom);
      it.led_levels = 8'($urandom);
      it.stage = 8'($urandom);
      it.eeprom_byte = 8'($urandom);
      it.eeprom_locked = 8'($urandom);
      it.tpu_power_state = 8'($urandom);
      return it;
   endfunction

   function automatic logic [7:0] pick_data();
      return ($urandom_range(0, 5) == 0) ? itrb_pkg::TEST_IRQ_CODE : 8'($urandom);
   endfunction

   // index byte: mostly a mapped register or the window, sometimes aliased by +101
   function automatic logic [7:0] pick_index();
      logic [7:0] target;
      case ($urandom_range(0, 3))
         0: target = 8'($urandom);
         1: target = 8'(int'(itrb_pkg::REG_WINDOW) +
                        $urandom_range(0, itrb_pkg::WINDOW_SIZE - 1));
         default: target = {1'b0, MAPPED[$urandom_range(0, $size(MAPPED) - 1)]};
      endcase
      if (int'(target) < 256 - itrb_pkg::REGISTER_COUNT && $urandom_range(0, 3) == 0)
         target = target + 8'(itrb_pkg::REGISTER_COUNT);
      return target;
   endfunction

   task automatic send_item(itrb_pkg::req_type it, bit typed = 1'b0,
                            itrb_pkg::rsp_type r = '0);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= it;
      row_typed <= typed;
      row_reply <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [7:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic program_bank(logic [7:0] board, logic [7:0] fw, logic [7:0] hw,
                               logic [7:0] ddr, logic [7:0] mode, logic [7:0] leds,
                               logic [7:0] mask);
      write_csr(itrb_pkg::CSR_BOARD_TYPE, board);
      write_csr(itrb_pkg::CSR_FIRMWARE_VERSION, fw);
      write_csr(itrb_pkg::CSR_HARDWARE_VERSION, hw);
      write_csr(itrb_pkg::CSR_DDR_TYPE, ddr);
      write_csr(itrb_pkg::CSR_WORK_MODE, mode);
      write_csr(itrb_pkg::CSR_LED_COUNT, leds);
      write_csr(itrb_pkg::CSR_TEST_IRQ_MASK, mask);
      csr_if.valid <= 1'b0;
   endtask

   // mostly complete transfers: start, index byte, a run of data bytes, stop
   task automatic run_transfers(int unsigned count);
      int unsigned sent;
      int unsigned len;
      int unsigned kind;
      bit          reading;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            send_item(bus_item(itrb_pkg::OP_START_WRITE, 8'($urandom)));
            send_item(bus_item(itrb_pkg::OP_WRITE_BYTE, pick_index()));
            len = $urandom_range(1, 6);
            reading = 1'($urandom_range(0, 1));
            for (int unsigned n = 0; n < len; n++) begin
               if ($urandom_range(0, 4) == 0) reading = !reading;
               send_item(bus_item(reading ? itrb_pkg::OP_READ_BYTE : itrb_pkg::OP_WRITE_BYTE,
                                  pick_data()));
            end
            send_item(bus_item(itrb_pkg::OP_STOP, 8'($urandom)));
            sent += len + 3;
         end else if (kind < 9) begin
            send_item(bus_item(3'($urandom_range(0, 7)), pick_data()));
            sent++;
         end else begin
            send_item(bus_item(itrb_pkg::OP_START_WRITE, 8'($urandom)));
            if ($urandom_range(0, 1) == 0) begin
               send_item(bus_item(itrb_pkg::OP_WRITE_BYTE, pick_index()));
               sent++;
            end
            send_item(bus_item(3'($urandom_range(0, 7)), pick_data()));
            sent += 2;
         end
      end
   endtask

   initial begin : rsp_pacing
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      row_typed <= 1'b0;
      row_reply <= '0;
      directed = '{
         known(itrb_pkg::OP_READ_BYTE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_START_WRITE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, {1'b0, itrb_pkg::REG_COMMAND}, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_READ_BYTE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_READ_BYTE, 8'h00, reply(itrb_pkg::UNMAPPED_BYTE, 1'b0)),
         known(itrb_pkg::OP_START_WRITE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, 8'hff, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_START_WRITE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, {1'b0, itrb_pkg::REG_TEST_IRQ}, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, itrb_pkg::TEST_IRQ_CODE, reply(8'h00, 1'b1)),
         known(itrb_pkg::OP_START_WRITE, 8'h00, reply(8'h00, 1'b1)),
         known(itrb_pkg::OP_WRITE_BYTE, {1'b0, itrb_pkg::REG_IRQ_STATUS},
               reply(8'h00, 1'b1)),
         known(itrb_pkg::OP_WRITE_BYTE, 8'hff, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_RAISE_IRQ, 8'h80, reply(8'h00, 1'b1)),
         known(OP_UNDEFINED, 8'h00, reply(8'h00, 1'b1)),
         known(itrb_pkg::OP_BUS_RESET, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_START_WRITE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, {1'b0, itrb_pkg::REG_LED}, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_READ_BYTE, 8'h00, reply(8'hff, 1'b0)),
         known(itrb_pkg::OP_START_WRITE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE,
               8'(int'(itrb_pkg::REG_WINDOW) + itrb_pkg::WINDOW_SIZE - 1),
               reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, 8'ha5,
               reply(8'h00, 1'b0, itrb_pkg::ACT_EEPROM_WRITE,
                     16'(itrb_pkg::WINDOW_SIZE - 1), 8'ha5)),
         free_row(itrb_pkg::OP_READ_BYTE, 8'h00),
         known(itrb_pkg::OP_START_WRITE, 8'h00, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, {1'b0, itrb_pkg::REG_COMMAND}, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_WRITE_BYTE, 8'h77, reply(8'h00, 1'b0)),
         known(itrb_pkg::OP_STOP, 8'h00,
               reply(8'h00, 1'b0, itrb_pkg::ACT_COMMAND, 16'h0000, 8'h77)),
         known(itrb_pkg::OP_STOP, 8'h00, reply(8'h00, 1'b0))
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k])
         send_item(bus_item(directed[k].op, directed[k].data), directed[k].typed,
                   directed[k].reply);
      run_transfers(150);
      settle();

      write_csr(CSR_UNUSED, 8'hff);
      program_bank(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      run_transfers(200);
      settle();

      program_bank(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      run_transfers(200);
      settle();

      program_bank(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'(itrb_pkg::LED_MAX), 8'($urandom));
      run_transfers(200);
      settle();

      program_bank(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom_range(0, 15)), 8'($urandom));
      run_transfers(300);
      settle();

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
src/itrb_pkg.sv
src/itrb_channels.sv
src/itrb_csr.sv
src/itrb_core.sv
src/i2c_target_register_bank.sv
tb/testbench.sv
